FILE: rtl/core/fmts_pkg.sv
package fmts_pkg;

  // Default sizes of the stack.
  localparam int STACK_DEPTH_DEF = 8;
  localparam int ID_WIDTH_DEF    = 16;

  // Fixed field widths of the channels.
  localparam int PORT_ID_W    = 16;
  localparam int KIND_W       = 2;
  localparam int STATUS_W     = 2;
  localparam int PORT_COUNT_W = 4;

  // Action codes.
  localparam logic ACT_REQUEST = 1'b0;
  localparam logic ACT_ABANDON = 1'b1;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_DONE   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd2;

  // Commands broadcast from the sequencer to every cell of the row.
  typedef struct packed {
    logic clear;  // drop the match flag before a new search
    logic scan;   // advance the match flag one cell along the row
    logic push;   // shift entries towards the bottom, a new entry enters at the top
    logic pull;   // shift entries towards the top, closing the gap of a removed entry
  } fmts_cmd_t;

endpackage

FILE: rtl/core/fmts_cell.sv
module fmts_cell #(
  parameter int ID_WIDTH = fmts_pkg::ID_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  fmts_pkg::fmts_cmd_t         cmd,
  input  logic                        occupied,
  input  logic [ID_WIDTH-1:0]         key,
  input  logic                        seen_prev,
  input  logic [ID_WIDTH-1:0]         prev_id,
  input  logic [fmts_pkg::KIND_W-1:0] prev_kind,
  input  logic [ID_WIDTH-1:0]         next_id,
  input  logic [fmts_pkg::KIND_W-1:0] next_kind,
  output logic                        seen,
  output logic [ID_WIDTH-1:0]         id,
  output logic [fmts_pkg::KIND_W-1:0] kind
);

  // The match flag ripples one cell per cycle: after the sweep it is set in
  // every cell at or below the matching entry, counting from the top.
  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= 1'b0;
    end else if (cmd.clear) begin
      seen <= 1'b0;
    end else if (cmd.scan) begin
      seen <= seen_prev | (occupied && (id == key));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push && !seen_prev) begin
      id   <= prev_id;
      kind <= prev_kind;
    end else if (cmd.pull && seen) begin
      id   <= next_id;
      kind <= next_kind;
    end
  end

endmodule

FILE: rtl/core/focus_move_to_top_stack.sv
// Focus stack with move-to-front behaviour.
//
// The input channel (in_valid / in_ready) carries one beat per operation:
// action selects a focus request or an abandon for focus_id, and focus_kind
// gives the kind asked for. The output channel (out_valid / out_ready)
// returns exactly one beat per operation with the status and the top entry
// and entry count as they stand after the operation.
//
// Entries live in a row of cells with the top of the stack in cell 0. A
// search for the id passes a match flag down the row one cell per cycle in
// S_SCAN; S_APPLY then shifts the row and S_RESULT loads the result register.
// A beat is accepted only while the sequencer is idle, so a new beat is not
// taken until the previous operation has loaded its result register.
//
// The result register sits between the sequencer and the output port, so a
// new operation is accepted while a previous result waits; if the receiver
// still stalls when the new result is ready, the sequencer holds it until the
// register frees. Reset empties the stack; stored entry contents are not
// cleared because only held entries are ever read.
module focus_move_to_top_stack #(
  parameter int STACK_DEPTH = fmts_pkg::STACK_DEPTH_DEF,
  parameter int ID_WIDTH    = fmts_pkg::ID_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              action,
  input  logic [fmts_pkg::PORT_ID_W-1:0]    focus_id,
  input  logic [fmts_pkg::KIND_W-1:0]       focus_kind,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [fmts_pkg::STATUS_W-1:0]     status,
  output logic                              top_valid,
  output logic [fmts_pkg::PORT_ID_W-1:0]    top_id,
  output logic [fmts_pkg::KIND_W-1:0]       top_kind,
  output logic [fmts_pkg::PORT_COUNT_W-1:0] entry_count
);

  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam int SCAN_W = $clog2(STACK_DEPTH);

  // One-hot sequencer states.
  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_APPLY  = 4'b0100,
    S_RESULT = 4'b1000
  } state_t;

  state_t                        state, state_next;
  logic [SCAN_W-1:0]             scan_cnt;
  logic [CNT_W-1:0]              count;
  logic                          item_action;
  logic [ID_WIDTH-1:0]           item_id;
  logic [fmts_pkg::KIND_W-1:0]   item_kind;
  logic [fmts_pkg::STATUS_W-1:0] res_status;
  fmts_pkg::fmts_cmd_t           cmd;

  logic                          in_fire;
  logic                          out_free;
  logic                          found;
  logic                          full;

  logic                          seen  [STACK_DEPTH];
  logic [ID_WIDTH-1:0]           ids   [STACK_DEPTH];
  logic [fmts_pkg::KIND_W-1:0]   kinds [STACK_DEPTH];

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // After the sweep the bottom cell's flag tells whether the id is held.
  assign found = seen[STACK_DEPTH-1];
  assign full  = (count == CNT_W'(STACK_DEPTH));

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.clear  = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (scan_cnt == SCAN_W'(STACK_DEPTH - 1)) begin
          state_next = S_APPLY;
        end
      end
      S_APPLY: begin
        if (item_action == fmts_pkg::ACT_REQUEST) begin
          cmd.push = !full;
        end else begin
          cmd.pull = found;
        end
        state_next = S_RESULT;
      end
      S_RESULT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      scan_cnt  <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (in_fire) begin
        scan_cnt <= '0;
      end else if (state == S_SCAN) begin
        scan_cnt <= scan_cnt + SCAN_W'(1);
      end
      if (cmd.push && !found) begin
        count <= count + CNT_W'(1);
      end else if (cmd.pull) begin
        count <= count - CNT_W'(1);
      end
      if (state == S_RESULT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Operation being worked on, and its status once the row has been shifted.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_action <= action;
      item_id     <= ID_WIDTH'(focus_id);
      item_kind   <= focus_kind;
    end
    if (state == S_APPLY) begin
      if (item_action == fmts_pkg::ACT_REQUEST) begin
        res_status <= full ? fmts_pkg::ST_FULL : fmts_pkg::ST_DONE;
      end else begin
        res_status <= found ? fmts_pkg::ST_DONE : fmts_pkg::ST_ABSENT;
      end
    end
  end

  // Result register; the top of the stack is always cell 0.
  always_ff @(posedge clk) begin
    if (state == S_RESULT && out_free) begin
      status      <= res_status;
      top_valid   <= (count != '0);
      top_id      <= (count != '0) ? fmts_pkg::PORT_ID_W'(ids[0]) : '0;
      top_kind    <= (count != '0) ? kinds[0] : '0;
      entry_count <= fmts_pkg::PORT_COUNT_W'(count);
    end
  end

  // Row of cells. Cell 0 takes a new entry from the operation register and
  // sees no match above it; the bottom cell pulls in don't-care data.
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic                        seen_prev;
    logic [ID_WIDTH-1:0]         prev_id;
    logic [fmts_pkg::KIND_W-1:0] prev_kind;
    logic [ID_WIDTH-1:0]         next_id;
    logic [fmts_pkg::KIND_W-1:0] next_kind;

    if (i == 0) begin : g_top
      assign seen_prev = 1'b0;
      assign prev_id   = item_id;
      assign prev_kind = item_kind;
    end else begin : g_mid
      assign seen_prev = seen[i-1];
      assign prev_id   = ids[i-1];
      assign prev_kind = kinds[i-1];
    end

    if (i == STACK_DEPTH - 1) begin : g_bottom
      assign next_id   = '0;
      assign next_kind = '0;
    end else begin : g_upper
      assign next_id   = ids[i+1];
      assign next_kind = kinds[i+1];
    end

    fmts_cell #(
      .ID_WIDTH (ID_WIDTH)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .cmd       (cmd),
      .occupied  (count > CNT_W'(i)),
      .key       (item_id),
      .seen_prev (seen_prev),
      .prev_id   (prev_id),
      .prev_kind (prev_kind),
      .next_id   (next_id),
      .next_kind (next_kind),
      .seen      (seen[i]),
      .id        (ids[i]),
      .kind      (kinds[i])
    );
  end

endmodule

FILE: rtl/core/fmts_checker.sv
module fmts_checker #(
  parameter int STACK_DEPTH = fmts_pkg::STACK_DEPTH_DEF
) (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [fmts_pkg::STATUS_W-1:0]     status,
  input logic                              top_valid,
  input logic [fmts_pkg::PORT_ID_W-1:0]    top_id,
  input logic [fmts_pkg::KIND_W-1:0]       top_kind,
  input logic [fmts_pkg::PORT_COUNT_W-1:0] entry_count
);

  // A stalled result beat keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(top_id)
      && $stable(top_kind) && $stable(entry_count) && $stable(top_valid))
    else $error("result beat changed while stalled");

  // The block works on one operation at a time.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while an operation is in progress");

  // An empty stack reports a cleared top entry.
  a_top_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (top_valid == (entry_count != '0))
      && (top_valid || (top_id == '0 && top_kind == '0)))
    else $error("top entry disagrees with entry count");

  // A rejected request only happens on a full stack.
  a_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == fmts_pkg::ST_FULL
      |-> entry_count == fmts_pkg::PORT_COUNT_W'(STACK_DEPTH))
    else $error("request rejected although the stack is not full");

endmodule

bind focus_move_to_top_stack fmts_checker #(
  .STACK_DEPTH (STACK_DEPTH)
) u_fmts_checker (.*);
